// File: src/qwt_pkg.sv
package qwt_pkg;

	localparam int MAX_DELIMS_DEF = 4;
	localparam int DELIM_SLOTS    = 4;
	localparam int CFG_IDX_W      = 3;
	localparam int CNT_W          = 3;
	localparam int RES_MAX        = 3;
	localparam int RES_CNT_W      = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CUSTOM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELIM0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DELIM1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DELIM2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DELIM3 = 3'd5;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// open quote codes
	localparam logic [1:0] QUOTE_NONE   = 2'd0;
	localparam logic [1:0] QUOTE_SINGLE = 2'd1;
	localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        word_end;
		logic        string_end;
		logic [15:0] word_count;
		logic        run_last;
	} out_item_t;

	typedef struct packed {
		logic                 custom;
		logic [CNT_W-1:0]     count;
		logic [DELIM_SLOTS-1:0][7:0] delim;
	} cfg_t;

	// results of one item, awaiting delivery
	typedef struct packed {
		logic [RES_CNT_W-1:0]        cnt;
		out_item_t [RES_MAX-1:0]     res;
	} bundle_t;

endpackage

// File: src/qwt_cfg.sv
module qwt_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [qwt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	output qwt_pkg::cfg_t                 cfg
);
	import qwt_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.custom   <= 1'b0;
			cfg_q.count    <= '0;
			cfg_q.delim[0] <= 8'd32;
			cfg_q.delim[1] <= 8'd9;
			cfg_q.delim[2] <= 8'd44;
			cfg_q.delim[3] <= 8'd59;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CUSTOM: cfg_q.custom   <= cfg_data[0];
				REG_COUNT:  cfg_q.count    <= cfg_data[CNT_W-1:0];
				REG_DELIM0: cfg_q.delim[0] <= cfg_data;
				REG_DELIM1: cfg_q.delim[1] <= cfg_data;
				REG_DELIM2: cfg_q.delim[2] <= cfg_data;
				REG_DELIM3: cfg_q.delim[3] <= cfg_data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

endmodule

// File: src/qwt_core.sv
module qwt_core #(
	parameter int MAX_DELIMS = qwt_pkg::MAX_DELIMS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  qwt_pkg::in_item_t in_item,
	input  qwt_pkg::cfg_t     cfg,
	input  logic              load_ok,
	output logic              load,
	output qwt_pkg::bundle_t  bundle
);
	import qwt_pkg::*;

	localparam int LIM = (MAX_DELIMS < DELIM_SLOTS) ? MAX_DELIMS : DELIM_SLOTS;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic        in_word_q;
	logic [1:0]  quote_q;
	logic        hold_q;
	logic [15:0] words_q;

	logic        iw_c, h_c, wb_c, d_c, wend_c;
	logic [1:0]  q_c, qq_c;
	logic [15:0] w_c;
	logic [RES_CNT_W-1:0] n_c;
	out_item_t [RES_MAX-1:0] res_c;

	assign load     = valid_s1 && load_ok;
	assign in_ready = !valid_s1 || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_item.in_byte;
			last_s1 <= in_item.in_last;
		end
	end

	// delimiter match
	always_comb begin
		d_c = 1'b0;
		if (!cfg.custom) begin
			d_c = (byte_s1 >= CH_TAB && byte_s1 <= CH_CR) || byte_s1 == CH_SPACE;
		end else begin
			for (int i = 0; i < DELIM_SLOTS; i++) begin
				if (i < LIM && i < int'(cfg.count) && cfg.delim[i] == byte_s1)
					d_c = 1'b1;
			end
		end
	end

	always_comb begin
		iw_c   = in_word_q;
		q_c    = quote_q;
		h_c    = hold_q;
		w_c    = words_q;
		wb_c   = 1'b0;
		wend_c = 1'b0;
		n_c    = '0;
		qq_c   = (byte_s1 == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
		res_c  = '0;

		if (!iw_c) begin
			if (!d_c) begin
				iw_c = 1'b1;
				q_c  = QUOTE_NONE;
				h_c  = 1'b0;
				wb_c = 1'b1;
			end
		end else if (h_c) begin
			h_c = 1'b0;
			if (d_c || (q_c == QUOTE_SINGLE && byte_s1 == CH_SQUOTE)
				|| (q_c == QUOTE_DOUBLE && byte_s1 == CH_DQUOTE)) begin
				res_c[n_c].out_byte   = byte_s1;
				res_c[n_c].byte_valid = 1'b1;
				res_c[n_c].word_count = w_c;
				n_c = n_c + 1'b1;
			end else begin
				res_c[n_c].out_byte   = CH_BSLASH;
				res_c[n_c].byte_valid = 1'b1;
				res_c[n_c].word_count = w_c;
				n_c  = n_c + 1'b1;
				wb_c = 1'b1;
			end
		end else begin
			wb_c = 1'b1;
		end

		if (wb_c) begin
			if (q_c == QUOTE_NONE && d_c) begin
				w_c  = (w_c == 16'hFFFF) ? w_c : w_c + 16'd1;
				iw_c = 1'b0;
				q_c  = QUOTE_NONE;
				h_c  = 1'b0;
				res_c[n_c].word_end   = 1'b1;
				res_c[n_c].word_count = w_c;
				n_c = n_c + 1'b1;
			end else if (byte_s1 == CH_DQUOTE || byte_s1 == CH_SQUOTE) begin
				if (q_c == QUOTE_NONE) begin
					q_c = qq_c;
				end else if (q_c == qq_c) begin
					q_c = QUOTE_NONE;
				end else begin
					// the other quote inside a span is an ordinary byte
					res_c[n_c].out_byte   = byte_s1;
					res_c[n_c].byte_valid = 1'b1;
					res_c[n_c].word_count = w_c;
					n_c = n_c + 1'b1;
				end
			end else if (byte_s1 == CH_BSLASH) begin
				h_c = 1'b1;
			end else begin
				res_c[n_c].out_byte   = byte_s1;
				res_c[n_c].byte_valid = 1'b1;
				res_c[n_c].word_count = w_c;
				n_c = n_c + 1'b1;
			end
		end

		if (last_s1) begin
			if (iw_c) begin
				if (h_c) begin
					res_c[n_c].out_byte   = CH_BSLASH;
					res_c[n_c].byte_valid = 1'b1;
					res_c[n_c].word_count = w_c;
					n_c = n_c + 1'b1;
				end
				w_c    = (w_c == 16'hFFFF) ? w_c : w_c + 16'd1;
				wend_c = 1'b1;
			end
			res_c[n_c].word_end   = wend_c;
			res_c[n_c].string_end = 1'b1;
			res_c[n_c].word_count = w_c;
			n_c  = n_c + 1'b1;
			iw_c = 1'b0;
			q_c  = QUOTE_NONE;
			h_c  = 1'b0;
			w_c  = '0;
		end
	end

	assign bundle.cnt = n_c;
	assign bundle.res = res_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q <= 1'b0;
			quote_q   <= QUOTE_NONE;
			hold_q    <= 1'b0;
			words_q   <= '0;
		end else if (load) begin
			in_word_q <= iw_c;
			quote_q   <= q_c;
			hold_q    <= h_c;
			words_q   <= w_c;
		end
	end

endmodule

// File: src/qwt_out.sv
module qwt_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  qwt_pkg::bundle_t   bundle,
	output logic               load_ok,
	output logic               out_valid,
	input  logic               out_ready,
	output qwt_pkg::out_item_t out_item
);
	import qwt_pkg::*;

	logic [RES_CNT_W-1:0]    cnt_q;
	logic [RES_CNT_W-1:0]    idx_q;
	out_item_t [RES_MAX-1:0] res_q;
	logic                    final_c;

	assign out_valid = cnt_q != '0;
	assign final_c   = idx_q == cnt_q - 1'b1;
	assign load_ok   = !out_valid || (out_ready && final_c);

	always_comb begin
		out_item          = res_q[idx_q];
		out_item.run_last = final_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= bundle.cnt;
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			if (final_c) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= bundle.res;
	end

endmodule

// File: src/quoted_word_tokenizer.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_item   (in_byte, in_last)
// out      output     out_valid / out_ready out_item  (one result item)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An input item is taken when the input register is empty or its item moves
// on. An item lands in the input register, is decoded in one pass against
// the word/quote/backslash state, and its zero to three result items go into
// the result register together. Results leave one per cycle while out_ready
// is high; the next item loads as the last result of the one before is taken,
// or at once if the result register is empty. Reset clears state, valids and
// configuration. A stalled output holds the input register; in_ready drops.
module quoted_word_tokenizer #(
	parameter int MAX_DELIMS = qwt_pkg::MAX_DELIMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  qwt_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output qwt_pkg::out_item_t            out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [qwt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import qwt_pkg::*;

	cfg_t    cfg;
	bundle_t bundle;
	logic    load;
	logic    load_ok;

	// configuration registers, reset to whitespace mode
	qwt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register, tokenizer state and the single-pass decode
	qwt_core #(
		.MAX_DELIMS (MAX_DELIMS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cfg      (cfg),
		.load_ok  (load_ok),
		.load     (load),
		.bundle   (bundle)
	);

	// result register; hands items out one at a time, marks the last of a run
	qwt_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle    (bundle),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
